// ----- rtl/core/dp2p_pkg.sv -----
// ----------------------------------------------------------------------------
// dp2p_pkg
// Types and register indexes shared by the depth pixel to point block.
// ----------------------------------------------------------------------------
package dp2p_pkg;

	// configuration port widths
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_SCALE   = 3'd0,
		REG_CENTER_X    = 3'd1,
		REG_CENTER_Y    = 3'd2,
		REG_INV_FOCAL_X = 3'd3,
		REG_INV_FOCAL_Y = 3'd4
	} cfg_reg_t;

	// register reset values
	localparam logic [23:0] INV_SCALE_RST   = 24'd16777;
	localparam logic [15:0] CENTER_X_RST    = 16'd5208;
	localparam logic [15:0] CENTER_Y_RST    = 16'd4056;
	localparam logic [23:0] INV_FOCAL_X_RST = 24'd32389;
	localparam logic [23:0] INV_FOCAL_Y_RST = 24'd32326;

	// input beat
	typedef struct packed {
		logic [11:0] column_index;
		logic [11:0] row_index;
		logic [15:0] depth_raw;
		logic [7:0]  pixel_blue;
		logic [7:0]  pixel_green;
		logic [7:0]  pixel_red;
	} pixel_t;

	// output beat
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic [31:0]        point_z;
		logic [7:0]         color_blue;
		logic [7:0]         color_green;
		logic [7:0]         color_red;
	} point_t;

endpackage

// ----- rtl/core/depth_pixel_to_point.sv -----
// Each accepted input beat passes the stage 1 to stage 5 registers to its output.
// Throughput: one pixel per cycle while out_ready does not stall the output; the
// five-stage multiply pipeline sets it.
// Skipped pixels and zero depth take no pipeline slot and give no beat.
// Reset clears all stage valids and loads the default camera intrinsics.
// ----------------------------------------------------------------------------
// depth_pixel_to_point
// Back-projects a subsampled depth pixel to a fixed-point 3D point with colour
// using reciprocal pinhole intrinsics.
// ----------------------------------------------------------------------------
module depth_pixel_to_point #(
	parameter int SUBSAMPLE = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [dp2p_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dp2p_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  dp2p_pkg::pixel_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output dp2p_pkg::point_t                     out_data
);
	import dp2p_pkg::*;

	// reciprocal for the subsample divisibility test: exact for 12-bit indexes
	localparam int          RECIP_SH = 15;
	localparam int          RECIP    = (2**RECIP_SH + SUBSAMPLE - 1) / SUBSAMPLE;
	localparam logic [15:0] RECIP_C  = 16'(RECIP);
	localparam logic [3:0]  SUB_C    = 4'(SUBSAMPLE);

	// configuration registers
	logic [23:0] inv_scale_q;
	logic [15:0] center_x_q;
	logic [15:0] center_y_q;
	logic [23:0] inv_focal_x_q;
	logic [23:0] inv_focal_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_scale_q   <= INV_SCALE_RST;
			center_x_q    <= CENTER_X_RST;
			center_y_q    <= CENTER_Y_RST;
			inv_focal_x_q <= INV_FOCAL_X_RST;
			inv_focal_y_q <= INV_FOCAL_Y_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_INV_SCALE:   inv_scale_q   <= cfg_data;
				REG_CENTER_X:    center_x_q    <= cfg_data[15:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[15:0];
				REG_INV_FOCAL_X: inv_focal_x_q <= cfg_data;
				REG_INV_FOCAL_Y: inv_focal_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// lane 0 is x (column), lane 1 is y (row)
	logic [1:0][15:0] center_l;
	logic [1:0][23:0] inv_l;
	logic [1:0][11:0] pix_l;

	assign center_l = {center_y_q, center_x_q};
	assign inv_l    = {inv_focal_y_q, inv_focal_x_q};
	assign pix_l    = {in_data.row_index, in_data.column_index};

	// stage valids and advance enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	// stage 1 logic: subsample test, depth scale, centered pixel offset
	logic [1:0]       keep_l;
	logic [1:0][27:0] qprod_l;
	logic [1:0][15:0] back_l;
	logic [1:0][15:0] p16_l;
	logic [1:0]       neg_c;
	logic [1:0][15:0] d_c;
	logic [39:0]      zprod_c;
	logic             keep_c;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qprod_l[i] = 28'(pix_l[i]) * 28'(RECIP_C);
			back_l[i]  = 16'(qprod_l[i][26:RECIP_SH]) * 16'(SUB_C);
			keep_l[i]  = (back_l[i] == 16'(pix_l[i]));
			p16_l[i]   = {pix_l[i], 4'b0000};
			neg_c[i]   = p16_l[i] < center_l[i];
			d_c[i]     = neg_c[i] ? (center_l[i] - p16_l[i]) : (p16_l[i] - center_l[i]);
		end
		zprod_c = 40'(in_data.depth_raw) * 40'(inv_scale_q);
		keep_c  = keep_l[0] && keep_l[1] && (in_data.depth_raw != 16'd0);
	end

	// pipeline payload registers
	logic [31:0]      z_s1, z_s2, z_s3, z_s4, z_s5;
	logic [23:0]      rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5;
	logic [1:0]       neg_s1, neg_s2, neg_s3, neg_s4;
	logic [1:0][15:0] d_s1;
	logic [1:0][47:0] a_s2;
	logic [1:0][47:0] plo_s3, phi_s3;
	logic [1:0][43:0] q_s4;
	logic [1:0]       rem_s4;
	logic [1:0][31:0] pt_s5;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid && keep_c;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: depth to z, pixel offsets
	always_ff @(posedge clk) begin
		if (en_s1) begin
			z_s1   <= zprod_c[39:8];
			d_s1   <= d_c;
			neg_s1 <= neg_c;
			rgb_s1 <= {in_data.pixel_blue, in_data.pixel_green, in_data.pixel_red};
		end
	end

	// stage 2: offset times z
	always_ff @(posedge clk) begin
		if (en_s2) begin
			for (int i = 0; i < 2; i++) begin
				a_s2[i] <= 48'(d_s1[i]) * 48'(z_s1);
			end
			neg_s2 <= neg_s1;
			z_s2   <= z_s1;
			rgb_s2 <= rgb_s1;
		end
	end

	// stage 3: split product times reciprocal focal length
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < 2; i++) begin
				plo_s3[i] <= 48'(a_s2[i][23:0]) * 48'(inv_l[i]);
				phi_s3[i] <= 48'(a_s2[i][47:24]) * 48'(inv_l[i]);
			end
			neg_s3 <= neg_s2;
			z_s3   <= z_s2;
			rgb_s3 <= rgb_s2;
		end
	end

	// stage 4: recombine partial products, shift down by 28
	logic [1:0][71:0] full_c;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			full_c[i] = {phi_s3[i], 24'd0} + 72'(plo_s3[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int i = 0; i < 2; i++) begin
				q_s4[i]   <= full_c[i][71:28];
				rem_s4[i] <= |full_c[i][27:0];
			end
			neg_s4 <= neg_s3;
			z_s4   <= z_s3;
			rgb_s4 <= rgb_s3;
		end
	end

	// stage 5: floor toward minus infinity, sign and saturate
	logic [1:0][44:0] qn_c;
	logic [1:0][31:0] pt_c;

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			qn_c[i] = 45'(q_s4[i]) + 45'(rem_s4[i]);
			if (!neg_s4[i]) begin
				pt_c[i] = (|q_s4[i][43:31]) ? 32'h7fff_ffff : {1'b0, q_s4[i][30:0]};
			end else if ((|qn_c[i][44:32]) || (qn_c[i][31] && (|qn_c[i][30:0]))) begin
				pt_c[i] = 32'h8000_0000;
			end else begin
				pt_c[i] = 32'd0 - qn_c[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			pt_s5  <= pt_c;
			z_s5   <= z_s4;
			rgb_s5 <= rgb_s4;
		end
	end

	// output beat
	assign out_valid            = v_s5;
	assign out_data.point_x     = pt_s5[0];
	assign out_data.point_y     = pt_s5[1];
	assign out_data.point_z     = z_s5;
	assign out_data.color_blue  = rgb_s5[23:16];
	assign out_data.color_green = rgb_s5[15:8];
	assign out_data.color_red   = rgb_s5[7:0];

endmodule

// ----- tb/sv/dp2p_point_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dp2p_point_checker
// Watches the register port and both pixel and point channels of the depth
// pixel to point block, predicts each point beat from the accepted pixel
// beats and its own copy of the camera registers, and compares in order.
// ----------------------------------------------------------------------------
module dp2p_point_checker #(
	parameter int SUBSAMPLE = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [dp2p_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dp2p_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  dp2p_pkg::pixel_t                     in_data,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  dp2p_pkg::point_t                     out_data,
	output int                                   fail_count,
	output int                                   pending,
	output int                                   points_checked
);

	import dp2p_pkg::*;

	localparam logic signed [79:0] SAT_HI = 80'sh7FFFFFFF;
	localparam logic signed [79:0] SAT_LO = -80'sh80000000;

	// shadow copy of the camera registers
	logic [23:0] inv_scale;
	logic [15:0] center_x;
	logic [15:0] center_y;
	logic [23:0] inv_focal_x;
	logic [23:0] inv_focal_y;

	point_t expected_points[$];
	point_t want_point;

	// pixel lands on the subsample grid and carries a depth
	function automatic bit pixel_kept(input pixel_t px);
		return (px.column_index % SUBSAMPLE) == 0 && (px.row_index % SUBSAMPLE) == 0 &&
			px.depth_raw != 16'd0;
	endfunction

	// (pix*16 - center) * z * inv >> 28, floor, saturated to signed 32 bits
	function automatic logic [31:0] project_axis(input logic [11:0] pix,
		input logic [15:0] center, input logic [31:0] z, input logic [23:0] inv_focal);
		logic signed [79:0] offset;
		logic signed [79:0] wide;
		offset = {64'd0, pix, 4'd0} - {64'd0, center};
		wide = offset * $signed({48'd0, z}) * $signed({56'd0, inv_focal});
		wide = wide >>> 28;
		if (wide > SAT_HI)
			return 32'h7FFFFFFF;
		if (wide < SAT_LO)
			return 32'h80000000;
		return wide[31:0];
	endfunction

	// back-project one pixel with the current intrinsics
	function automatic point_t project_pixel(input pixel_t px);
		point_t pt;
		logic [39:0] scaled;
		scaled = px.depth_raw * inv_scale;
		pt.point_z     = scaled[39:8];
		pt.point_x     = project_axis(px.column_index, center_x, pt.point_z, inv_focal_x);
		pt.point_y     = project_axis(px.row_index, center_y, pt.point_z, inv_focal_y);
		pt.color_blue  = px.pixel_blue;
		pt.color_green = px.pixel_green;
		pt.color_red   = px.pixel_red;
		return pt;
	endfunction

	function automatic int field_mismatch(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %h, got %h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	// register shadow, prediction on pixel beats, comparison on point beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_scale      <= INV_SCALE_RST;
			center_x       <= CENTER_X_RST;
			center_y       <= CENTER_Y_RST;
			inv_focal_x    <= INV_FOCAL_X_RST;
			inv_focal_y    <= INV_FOCAL_Y_RST;
			fail_count     <= 0;
			pending        <= 0;
			points_checked <= 0;
			expected_points.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_INV_SCALE:   inv_scale   <= cfg_data;
					REG_CENTER_X:    center_x    <= cfg_data[15:0];
					REG_CENTER_Y:    center_y    <= cfg_data[15:0];
					REG_INV_FOCAL_X: inv_focal_x <= cfg_data;
					REG_INV_FOCAL_Y: inv_focal_y <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready && pixel_kept(in_data))
				expected_points = {expected_points, project_pixel(in_data)};
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					$error("point beat with no pixel waiting for it");
					fail_count <= fail_count + 1;
				end else begin
					want_point = expected_points.pop_front();
					fail_count <= fail_count +
						field_mismatch("point_x", want_point.point_x, out_data.point_x) +
						field_mismatch("point_y", want_point.point_y, out_data.point_y) +
						field_mismatch("point_z", want_point.point_z, out_data.point_z) +
						field_mismatch("color_blue", want_point.color_blue, out_data.color_blue) +
						field_mismatch("color_green", want_point.color_green,
							out_data.color_green) +
						field_mismatch("color_red", want_point.color_red, out_data.color_red);
					points_checked <= points_checked + 1;
				end
			end
			pending <= expected_points.size();
		end
	end

endmodule

// ----- tb/sv/tb_depth_pixel_to_point.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_depth_pixel_to_point
// Drives pixel beats and camera register settings into the depth pixel to
// point block under several idling patterns and a long output hold-off; the
// point checker beside the block predicts and compares every point beat.
// ----------------------------------------------------------------------------
module tb_depth_pixel_to_point;

	import dp2p_pkg::*;

	localparam int SUBSAMPLE        = 2;
	localparam int LATENCY          = 5;
	localparam int HOLD_CYCLES      = 300;
	localparam int STALL_LIMIT      = 4000;
	localparam int PHASES           = 4;
	localparam int RANDOM_PER_PHASE = 345;
	localparam logic [CFG_IDX_W-1:0] NO_SUCH_REG = 3'd7;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	pixel_t                in_data;
	logic                  out_valid;
	logic                  out_ready;
	point_t                out_data;

	int fail_count;
	int pending;
	int points_checked;
	int tx_idle_pct;
	int rx_stall_pct;
	int pixels_sent;
	int settings_used;
	int idle_cycles;
	bit hold_req;

	depth_pixel_to_point #(
		.SUBSAMPLE(SUBSAMPLE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	dp2p_point_checker #(
		.SUBSAMPLE(SUBSAMPLE)
	) point_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.fail_count(fail_count),
		.pending(pending),
		.points_checked(points_checked)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// point receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			out_ready <= arst_n && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic pixel_t mk_pixel(input logic [11:0] col, input logic [11:0] row,
		input logic [15:0] depth, input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] r);
		pixel_t px;
		px.column_index = col;
		px.row_index    = row;
		px.depth_raw    = depth;
		px.pixel_blue   = b;
		px.pixel_green  = g;
		px.pixel_red    = r;
		return px;
	endfunction

	// mostly on-grid pixels with depth, the rest unconstrained noise
	function automatic pixel_t random_pixel();
		pixel_t px;
		px = pixel_t'({$urandom(), $urandom()});
		if ($urandom_range(99) < 75) begin
			px.column_index = 12'(px.column_index - px.column_index % SUBSAMPLE);
			px.row_index    = 12'(px.row_index - px.row_index % SUBSAMPLE);
			px.depth_raw    = 16'($urandom_range(1) ? $urandom_range(65535, 1) :
				$urandom_range(4000, 1));
		end
		return px;
	endfunction

	// one pixel beat, with random idle cycles ahead of it
	task automatic send_pixel(input pixel_t px);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pixels_sent++;
	endtask

	// stop sending and let every predicted point come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// all five registers plus a write to an unmapped index
	task automatic configure(input logic [CFG_DATA_W-1:0] scale,
		input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
		input logic [CFG_DATA_W-1:0] fx, input logic [CFG_DATA_W-1:0] fy);
		write_reg(REG_INV_SCALE, scale);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_INV_FOCAL_X, fx);
		write_reg(REG_INV_FOCAL_Y, fy);
		write_reg(NO_SUCH_REG, CFG_DATA_W'($urandom()));
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		in_data      = '0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		pixels_sent  = 0;
		settings_used = 1;
		hold_req     = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset intrinsics: corners, near the principal point, skips, no depth
		send_pixel(mk_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00));
		send_pixel(mk_pixel(12'd4094, 12'd4094, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_pixel(mk_pixel(12'd326, 12'd254, 16'd1000, 8'h12, 8'h34, 8'h56));
		send_pixel(mk_pixel(12'd324, 12'd252, 16'd1000, 8'hA5, 8'h5A, 8'hC3));
		send_pixel(mk_pixel(12'd4095, 12'd0, 16'd500, 8'h01, 8'h02, 8'h03));
		send_pixel(mk_pixel(12'd0, 12'd4095, 16'd500, 8'h04, 8'h05, 8'h06));
		send_pixel(mk_pixel(12'd3, 12'd7, 16'd500, 8'h07, 8'h08, 8'h09));
		send_pixel(mk_pixel(12'd100, 12'd100, 16'd0, 8'h0A, 8'h0B, 8'h0C));
		send_pixel(mk_pixel(12'd2, 12'd2, 16'hFFFF, 8'hFF, 8'h00, 8'hFF));
		send_pixel(mk_pixel(12'd4094, 12'd0, 16'hFFFF, 8'h00, 8'hFF, 8'h00));
		wait_drained();

		// largest scale and focal terms, center at zero: positive saturation
		configure(24'hFFFFFF, 24'h0, 24'h0, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(mk_pixel(12'd4094, 12'd4094, 16'hFFFF, 8'h55, 8'hAA, 8'h55));
		send_pixel(mk_pixel(12'd0, 12'd0, 16'hFFFF, 8'hAA, 8'h55, 8'hAA));
		send_pixel(mk_pixel(12'd2, 12'd4094, 16'd1, 8'h81, 8'h42, 8'h24));
		wait_drained();

		// center written with wide data: negative saturation and floor rounding
		configure(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
		send_pixel(mk_pixel(12'd0, 12'd0, 16'hFFFF, 8'h11, 8'h22, 8'h33));
		send_pixel(mk_pixel(12'd4094, 12'd4094, 16'hFFFF, 8'h44, 8'h55, 8'h66));
		send_pixel(mk_pixel(12'd4094, 12'd4094, 16'd1, 8'h77, 8'h88, 8'h99));
		wait_drained();

		// zero scale and zero focal terms
		configure(24'h0, 24'h8000, 24'h8000, 24'h0, 24'h0);
		send_pixel(mk_pixel(12'd10, 12'd10, 16'hFFFF, 8'hDE, 8'hAD, 8'hBE));
		send_pixel(mk_pixel(12'd4094, 12'd0, 16'd1234, 8'hEF, 8'hCA, 8'hFE));
		wait_drained();

		// smallest nonzero terms
		configure(24'd1, 24'd16, 24'd16, 24'd1, 24'd1);
		send_pixel(mk_pixel(12'd0, 12'd0, 16'd255, 8'h3C, 8'hC3, 8'h0F));
		send_pixel(mk_pixel(12'd2, 12'd2, 16'hFFFF, 8'hF0, 8'h0F, 8'h3C));
		wait_drained();

		// random phases, each with its own intrinsics and idling pattern
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
				default: begin tx_idle_pct = 17; rx_stall_pct = 17; end
			endcase
			if (phase % 2 == 0)
				configure(CFG_DATA_W'($urandom_range(70000, 1000)),
					CFG_DATA_W'($urandom_range(65535)),
					CFG_DATA_W'($urandom_range(65535)),
					CFG_DATA_W'($urandom_range(200000, 5000)),
					CFG_DATA_W'($urandom_range(200000, 5000)));
			else
				configure(CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
					CFG_DATA_W'($urandom()), CFG_DATA_W'($urandom()),
					CFG_DATA_W'($urandom()));
			for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
				// long output hold-off while pixels keep coming
				if (phase == 0 && i == 120)
					hold_req = 1'b1;
				send_pixel(random_pixel());
			end
			wait_drained();
		end

		$display("covered %0d pixel beats and %0d point beats over %0d register settings",
			pixels_sent, points_checked, settings_used);
		$display("idling mixes: none, sender, receiver, both; one long output hold-off");
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
